@@ src/camera_sync_handshake_macros.svh @@
// Assertion macros shared by the camera sync handshake block.
`ifndef CAMERA_SYNC_HANDSHAKE_MACROS_SVH
`define CAMERA_SYNC_HANDSHAKE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CSH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define CSH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/csh_pkg.sv @@
// Types, constants and helper functions of the camera sync handshake block.
`timescale 1ns / 1ps

package csh_pkg;

   localparam int REPLY_BYTES  = 12;
   localparam int PACKET_BYTES = 6;
   localparam int FIFO_DEPTH   = 2;

   localparam logic [7:0] MAX_ATTEMPTS_RST = 8'd254;
   localparam logic [7:0] SETTLE_TICKS_RST = 8'd5;
   localparam logic [7:0] GAP_TICKS_RST    = 8'd3;

   localparam logic [7:0] BYTE_SOF  = 8'hAA;
   localparam logic [7:0] BYTE_SYNC = 8'h0D;
   localparam logic [7:0] BYTE_ACK  = 8'h0E;
   localparam logic [7:0] BYTE_ZERO = 8'h00;

   // Commands.
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_TICK  = 2'd1;
   localparam logic [1:0] CMD_BYTE  = 2'd2;

   // Reported status.
   localparam logic [1:0] STAT_IDLE   = 2'd0;
   localparam logic [1:0] STAT_BUSY   = 2'd1;
   localparam logic [1:0] STAT_SYNCED = 2'd2;
   localparam logic [1:0] STAT_FAILED = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MAX_ATTEMPTS = 2'd0;
   localparam logic [1:0] CSR_SETTLE_TICKS = 2'd1;
   localparam logic [1:0] CSR_GAP_TICKS    = 2'd2;

   // Kinds of response bursts queued between the core and the serializer.
   localparam logic [1:0] KIND_SINGLE = 2'd0;
   localparam logic [1:0] KIND_SYNC   = 2'd1;
   localparam logic [1:0] KIND_ACK    = 2'd2;

   localparam int BEAT_W = $clog2(PACKET_BYTES);

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic [1:0] status;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [1:0] status;
   } desc_type;

   // Byte sent at a given beat of a sync or ack packet.
   function automatic logic [7:0] packet_byte(input logic [1:0] kind,
                                              input logic [BEAT_W-1:0] beat,
                                              input logic [7:0] data);
      logic [7:0] result;
      result = BYTE_ZERO;
      if (kind == KIND_SYNC) begin
         if (beat == BEAT_W'(0)) result = BYTE_SOF;
         else if (beat == BEAT_W'(1)) result = BYTE_SYNC;
      end else if (kind == KIND_ACK) begin
         if (beat == BEAT_W'(0)) result = BYTE_SOF;
         else if (beat == BEAT_W'(1)) result = BYTE_ACK;
         else if (beat == BEAT_W'(2)) result = BYTE_SYNC;
         else if (beat == BEAT_W'(3)) result = data;
      end
      return result;
   endfunction

endpackage

@@ src/csh_core.sv @@
// Handshake state machine: updates state per transaction and queues a burst descriptor.
`timescale 1ns / 1ps

module csh_core #(
   parameter int ReplyBytes = csh_pkg::REPLY_BYTES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_take,
   input  csh_pkg::req_type   req,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_wdata,
   output csh_pkg::desc_type  desc
);

   localparam int CntW = $clog2(ReplyBytes + 1);
   localparam logic [CntW-1:0] ReplyFull = CntW'(ReplyBytes);
   localparam logic [CntW-1:0] HeadBytes = CntW'(4);

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_SETTLE  = 3'd1;
   localparam logic [2:0] PH_COLLECT = 3'd2;
   localparam logic [2:0] PH_SYNCED  = 3'd3;
   localparam logic [2:0] PH_FAILED  = 3'd4;

   logic [7:0]      max_attempts_ff, settle_ticks_ff, gap_ticks_ff;
   logic [2:0]      phase_ff, phase_in;
   logic [7:0]      attempts_ff, attempts_in;
   logic [7:0]      tick_ff, tick_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [7:0]      head_ff [4];
   logic [7:0]      head_in [4];
   logic            head_we;
   logic [7:0]      tick_inc;
   logic            busy;
   logic            judge;
   logic            restart;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_attempts_ff <= csh_pkg::MAX_ATTEMPTS_RST;
         settle_ticks_ff <= csh_pkg::SETTLE_TICKS_RST;
         gap_ticks_ff    <= csh_pkg::GAP_TICKS_RST;
      end else if (csr_we) begin
         if (csr_index == csh_pkg::CSR_MAX_ATTEMPTS) max_attempts_ff <= csr_wdata;
         if (csr_index == csh_pkg::CSR_SETTLE_TICKS) settle_ticks_ff <= csr_wdata;
         if (csr_index == csh_pkg::CSR_GAP_TICKS) gap_ticks_ff <= csr_wdata;
      end
   end

   assign busy     = (phase_ff == PH_SETTLE) || (phase_ff == PH_COLLECT);
   assign tick_inc = (tick_ff == 8'hFF) ? tick_ff : tick_ff + 8'd1;
   assign head_we  = req_take && busy && (req.command == csh_pkg::CMD_BYTE)
                     && (count_ff < HeadBytes);

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         head_in[i] = head_ff[i];
      end
      if (head_we) head_in[count_ff[1:0]] = req.rx_byte;
   end

   always_comb begin
      phase_in    = phase_ff;
      attempts_in = attempts_ff;
      tick_in     = tick_ff;
      count_in    = count_ff;
      judge       = 1'b0;
      restart     = 1'b0;
      desc.kind   = csh_pkg::KIND_SINGLE;
      desc.data   = csh_pkg::BYTE_ZERO;
      desc.status = csh_pkg::STAT_IDLE;

      if (req.command == csh_pkg::CMD_START) begin
         attempts_in = 8'd0;
         restart     = 1'b1;
      end else if (req.command == csh_pkg::CMD_TICK && busy) begin
         tick_in = tick_inc;
         if (phase_ff == PH_SETTLE) begin
            if (tick_inc >= settle_ticks_ff) begin
               phase_in = PH_COLLECT;
               tick_in  = 8'd0;
               judge    = (count_ff >= ReplyFull);
            end
         end else begin
            judge = (tick_inc >= gap_ticks_ff);
         end
      end else if (req.command == csh_pkg::CMD_BYTE && busy) begin
         if (count_ff < ReplyFull) count_in = count_ff + CntW'(1);
         if (phase_ff == PH_COLLECT) begin
            tick_in = 8'd0;
            judge   = (count_in >= ReplyFull);
         end
      end

      if (judge) begin
         if (count_in == ReplyFull && head_in[0] == csh_pkg::BYTE_SOF
             && head_in[1] == csh_pkg::BYTE_ACK && head_in[2] == csh_pkg::BYTE_SYNC) begin
            phase_in = PH_SYNCED;
            desc.kind = csh_pkg::KIND_ACK;
            desc.data = head_in[3];
         end else if (attempts_ff >= max_attempts_ff) begin
            phase_in = PH_FAILED;
         end else begin
            restart = 1'b1;
         end
      end

      if (restart) begin
         // A start command clears the attempt count before this attempt is counted.
         if (attempts_in != 8'hFF) attempts_in = attempts_in + 8'd1;
         count_in  = '0;
         tick_in   = 8'd0;
         phase_in  = (settle_ticks_ff == 8'd0) ? PH_COLLECT : PH_SETTLE;
         desc.kind = csh_pkg::KIND_SYNC;
      end

      unique case (phase_in)
         PH_SETTLE, PH_COLLECT: desc.status = csh_pkg::STAT_BUSY;
         PH_SYNCED:             desc.status = csh_pkg::STAT_SYNCED;
         PH_FAILED:             desc.status = csh_pkg::STAT_FAILED;
         default:               desc.status = csh_pkg::STAT_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         attempts_ff <= 8'd0;
         tick_ff     <= 8'd0;
         count_ff    <= '0;
      end else if (req_take) begin
         phase_ff    <= phase_in;
         attempts_ff <= attempts_in;
         tick_ff     <= tick_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (head_we) head_ff[count_ff[1:0]] <= req.rx_byte;
   end

endmodule

@@ src/csh_fifo.sv @@
// Small descriptor queue between the state machine and the response serializer.
`timescale 1ns / 1ps

module csh_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  csh_pkg::desc_type push_data,
   input  logic              pop,
   output logic              full,
   output logic              avail,
   output csh_pkg::desc_type pop_data
);

   localparam int Depth = csh_pkg::FIFO_DEPTH;
   localparam int PtrW  = $clog2(Depth);
   localparam int CntW  = $clog2(Depth + 1);

   csh_pkg::desc_type mem_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CntW'(Depth));
   assign avail    = (count_ff != '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && avail;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + CntW'(1);
      else if (do_pop && !do_push) count_in = count_ff - CntW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + PtrW'(1);
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + PtrW'(1);
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

@@ src/csh_serializer.sv @@
// Expands each queued descriptor into one or six response transactions.
`timescale 1ns / 1ps

module csh_serializer (
   input  logic              clock,
   input  logic              reset,
   input  logic              desc_avail,
   input  csh_pkg::desc_type desc,
   output logic              desc_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output csh_pkg::rsp_type  rsp_data
);

   localparam int BeatW = csh_pkg::BEAT_W;
   localparam logic [BeatW-1:0] LastBeat = BeatW'(csh_pkg::PACKET_BYTES - 1);

   csh_pkg::desc_type cur_ff;
   logic [BeatW-1:0]  beat_ff;
   logic              busy_ff;
   logic              is_last;
   logic              sent;
   logic              load;

   assign is_last  = (cur_ff.kind == csh_pkg::KIND_SINGLE) || (beat_ff == LastBeat);
   assign sent     = busy_ff && !rsp_stall;
   assign load     = !busy_ff || (sent && is_last);
   assign desc_pop = load && desc_avail;

   assign rsp_valid         = busy_ff;
   assign rsp_data.tx_valid = (cur_ff.kind != csh_pkg::KIND_SINGLE);
   assign rsp_data.tx_byte  = csh_pkg::packet_byte(cur_ff.kind, beat_ff, cur_ff.data);
   assign rsp_data.status   = cur_ff.status;
   assign rsp_data.last     = is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         beat_ff <= '0;
      end else if (load) begin
         busy_ff <= desc_avail;
         beat_ff <= '0;
      end else if (sent) begin
         beat_ff <= beat_ff + BeatW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (desc_pop) cur_ff <= desc;
   end

endmodule

@@ src/camera_sync_handshake.sv @@
// Top level of the serial camera sync and acknowledge handshake.
//
//   channel  direction  handshake             carries
//   req      in         req_valid/req_stall   command, rx_byte
//   rsp      out        rsp_valid/rsp_stall   tx_valid, tx_byte, status, last
//   csr      in         csr_we                max_attempts, settle_ticks, gap_ticks
//
// When a transaction is taken, the state machine settles its state at the clock edge that
// takes it and queues a descriptor in a two-entry queue. The serializer sends one response per
// cycle while rsp_stall is low: six for a sync or ack packet, otherwise one, so the response
// port limits the sustained request rate. req_stall is high only while the queue is full.
// Reset is synchronous and returns the state and configuration registers to defaults.
`timescale 1ns / 1ps
`include "camera_sync_handshake_macros.svh"

module camera_sync_handshake #(
   parameter int ReplyBytes = csh_pkg::REPLY_BYTES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  csh_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output csh_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [7:0]       csr_wdata
);

   logic              req_take;
   logic              fifo_full;
   logic              desc_avail;
   logic              desc_pop;
   csh_pkg::desc_type new_desc;
   csh_pkg::desc_type head_desc;
   logic              tx_out;
   logic              single_out;
   logic              tx_status_ok;

   assign req_stall = fifo_full;
   assign req_take  = req_valid && !fifo_full;

   csh_core #(
      .ReplyBytes(ReplyBytes)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .req_take (req_take),
      .req      (req_data),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .desc     (new_desc)
   );

   csh_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (req_take),
      .push_data(new_desc),
      .pop      (desc_pop),
      .full     (fifo_full),
      .avail    (desc_avail),
      .pop_data (head_desc)
   );

   csh_serializer u_ser (
      .clock     (clock),
      .reset     (reset),
      .desc_avail(desc_avail),
      .desc      (head_desc),
      .desc_pop  (desc_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign tx_out       = rsp_valid && rsp_data.tx_valid;
   assign single_out   = rsp_valid && !rsp_data.tx_valid;
   assign tx_status_ok = (rsp_data.status == csh_pkg::STAT_BUSY)
                         || (rsp_data.status == csh_pkg::STAT_SYNCED);

   // An accepted request is either queued or already being sent on the next cycle.
   `CSH_ASSERT_NEXT(a_req_not_lost, clock, reset, req_take, rsp_valid || desc_avail, "req lost")

   // Packet bytes only ever go out while busy or synced.
   `CSH_ASSERT_NOW(a_tx_status, clock, reset, tx_out, tx_status_ok, "bad tx status")

   // A response without a byte is always a whole burst by itself.
   `CSH_ASSERT_NOW(a_single_last, clock, reset, single_out, rsp_data.last, "single not last")

endmodule
